@@ hw/rtl/c8ic_pkg.sv @@
package c8ic_pkg;

    typedef struct packed {
        logic [1:0]  command;
        logic [11:0] load_address;
        logic [7:0]  load_byte;
        logic [3:0]  key_index;
        logic        key_down;
        logic [7:0]  random_byte;
        logic [4:0]  row_select;
    } c8ic_in_t;

    typedef struct packed {
        logic [11:0] program_counter;
        logic [15:0] instruction;
        logic        sound_active;
        logic        waiting_key;
        logic [63:0] display_row;
    } c8ic_out_t;

    localparam logic [1:0] CMD_STEP = 2'd0;
    localparam logic [1:0] CMD_LOAD = 2'd1;
    localparam logic [1:0] CMD_KEY  = 2'd2;
    localparam logic [1:0] CMD_ROW  = 2'd3;

    localparam logic [15:0] OP_CLS = 16'h00E0;
    localparam logic [15:0] OP_RET = 16'h00EE;
    localparam logic [7:0] MISC_DLY_RD = 8'h07;
    localparam logic [7:0] MISC_KEYW   = 8'h0A;
    localparam logic [7:0] MISC_DLY_WR = 8'h15;
    localparam logic [7:0] MISC_SND_WR = 8'h18;
    localparam logic [7:0] MISC_ADDI   = 8'h1E;
    localparam logic [7:0] MISC_FONT   = 8'h29;
    localparam logic [7:0] MISC_BCD    = 8'h33;
    localparam logic [7:0] MISC_STORE  = 8'h55;
    localparam logic [7:0] MISC_LOADR  = 8'h65;
    localparam logic [7:0] KEY_DOWN_SK = 8'h9E;
    localparam logic [7:0] KEY_UP_SK   = 8'hA1;

    typedef enum logic [4:0] {
        ST_INIT, ST_IDLE, ST_FETCH0, ST_FETCH1, ST_FETCH2, ST_DEC, ST_EXEC,
        ST_BCD1, ST_BCD2, ST_STORE, ST_LOADR0, ST_LOADR1,
        ST_DRAW_RD, ST_DRAW_WT, ST_DRAW_FB, ST_DRAW_WR,
        ST_CLS, ST_ROW0, ST_ROW1, ST_DONE
    } c8ic_state_t;

    function automatic logic [7:0] font_byte(input logic [6:0] i);
        logic [7:0] f [80];
        f = '{8'hF0,8'h90,8'h90,8'h90,8'hF0, 8'h20,8'h60,8'h20,8'h20,8'h70,
              8'hF0,8'h10,8'hF0,8'h80,8'hF0, 8'hF0,8'h10,8'hF0,8'h10,8'hF0,
              8'h90,8'h90,8'hF0,8'h10,8'h10, 8'hF0,8'h80,8'hF0,8'h10,8'hF0,
              8'hF0,8'h80,8'hF0,8'h90,8'hF0, 8'hF0,8'h10,8'h20,8'h40,8'h40,
              8'hF0,8'h90,8'hF0,8'h90,8'hF0, 8'hF0,8'h90,8'hF0,8'h10,8'hF0,
              8'hF0,8'h90,8'hF0,8'h90,8'h90, 8'hE0,8'h90,8'hE0,8'h90,8'hE0,
              8'hF0,8'h80,8'h80,8'h80,8'hF0, 8'hE0,8'h90,8'h90,8'h90,8'hE0,
              8'hF0,8'h80,8'hF0,8'h80,8'hF0, 8'hF0,8'h80,8'hF0,8'h80,8'h80};
        return (i < 7'd80) ? f[i] : 8'h00;
    endfunction

endpackage

@@ hw/rtl/chip8_instruction_core_top.sv @@
// Channel  Direction  Payload      Handshake
// s_       in         c8ic_in_t    s_valid / s_ready
// m_       out        c8ic_out_t   m_valid / m_ready
// The path from acceptance to a valid result depends on the command (load or key
// command, row read, step, register transfer, screen clear or sprite draw) and is
// set by the registered reads of the byte memory and the frame row memory (read,
// then write back). The next item can be taken in the same cycle in which the
// result appears.
// After reset a clearing pass over the byte memory loads the font into memory and
// clears the frame rows; no item is accepted during it.
// One item is handled at a time; a finished result waits in the output
// register, and a following item stalls in its last state while that register is full.
module chip8_instruction_core_top #(
    parameter int PROGRAM_START = 512,
    parameter int FONT_BASE     = 80,
    parameter int STACK_DEPTH   = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  c8ic_pkg::c8ic_in_t s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output c8ic_pkg::c8ic_out_t m_data
);
    import c8ic_pkg::*;

    localparam int SPW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    c8ic_state_t state_reg, state_next;
    c8ic_in_t    item_reg, item_next;
    logic [7:0]  v_reg [16];
    logic [7:0]  v_next [16];
    logic [11:0] i_reg, i_next, pc_reg, pc_next;
    logic [SPW-1:0] sp_reg, sp_next;
    logic [11:0] stk_reg [STACK_DEPTH];
    logic        stk_we;
    logic [11:0] stk_wdata;
    logic [7:0]  dt_reg, dt_next, st_reg, st_next;
    logic [15:0] ir_reg, ir_next;
    logic [15:0] keys_reg, keys_next;
    logic [11:0] cnt_reg, cnt_next;
    logic [7:0]  tmp_reg, tmp_next;
    logic        wait_reg, wait_next;
    logic [63:0] row_reg, row_next;
    logic        mv_reg, mv_next;
    c8ic_out_t   out_reg, out_next;
    logic [5:0]  ox_reg, ox_next;
    logic [4:0]  oy_reg, oy_next;

    logic        mem_we;
    logic [11:0] mem_waddr, mem_raddr;
    logic [7:0]  mem_wdata, mem_rdata;
    logic        fb_we;
    logic [4:0]  fb_waddr, fb_raddr;
    logic [63:0] fb_wdata, fb_rdata;

    c8ic_ram #(.WIDTH(8), .DEPTH(4096)) u_mem (
        .aclk(aclk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
        .raddr(mem_raddr), .rdata(mem_rdata)
    );
    c8ic_ram #(.WIDTH(64), .DEPTH(32)) u_fb (
        .aclk(aclk), .we(fb_we), .waddr(fb_waddr), .wdata(fb_wdata),
        .raddr(fb_raddr), .rdata(fb_rdata)
    );

    logic [3:0]  x, y, n;
    logic [7:0]  vx, vy, nn, vf_mid;
    logic [11:0] nnn, pc2;
    logic [8:0]  sum9;
    logic [5:0]  ox;
    logic [4:0]  oy;
    logic [5:0]  rowsum;
    logic [63:0] spr_mask;
    logic [71:0] spr_wide;
    logic [11:0] font_off;
    logic [3:0]  first_key;
    logic        any_key;
    logic [7:0]  hund, rem1, tens, ones;

    assign x = ir_reg[11:8];
    assign y = ir_reg[7:4];
    assign n = ir_reg[3:0];
    assign nn = ir_reg[7:0];
    assign nnn = ir_reg[11:0];
    assign vx = v_reg[x];
    assign vy = v_reg[y];
    assign pc2 = pc_reg + 12'd2;
    assign ox = ox_reg;
    assign oy = oy_reg;
    assign rowsum = {1'b0, oy} + {2'b00, cnt_reg[3:0]};
    assign spr_wide = {tmp_reg, 64'd0} >> ox;
    assign spr_mask = spr_wide[71:8];
    assign font_off = 12'(FONT_BASE) + {4'd0, vx} + {2'd0, vx, 2'd0};

    always_comb begin
        first_key = '0;
        any_key = 1'b0;
        for (int k = 15; k >= 0; k--) begin
            if (keys_reg[k]) begin
                first_key = 4'(k);
                any_key = 1'b1;
            end
        end
    end

    always_comb begin
        hund = (vx >= 8'd200) ? 8'd2 : (vx >= 8'd100) ? 8'd1 : 8'd0;
        rem1 = vx - 8'(hund * 8'd100);
        tens = 8'((16'(rem1) * 16'd205) >> 11);
        ones = rem1 - 8'(tens * 8'd10);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
            for (int k = 0; k < 16; k++) v_reg[k] <= '0;
            for (int k = 0; k < STACK_DEPTH; k++) stk_reg[k] <= '0;
            i_reg <= '0;
            pc_reg <= 12'(PROGRAM_START);
            sp_reg <= '0;
            dt_reg <= '0;
            st_reg <= '0;
            ir_reg <= '0;
            keys_reg <= '0;
            cnt_reg <= '0;
            mv_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            for (int k = 0; k < 16; k++) v_reg[k] <= v_next[k];
            if (stk_we) stk_reg[sp_next] <= stk_wdata;
            i_reg <= i_next;
            pc_reg <= pc_next;
            sp_reg <= sp_next;
            dt_reg <= dt_next;
            st_reg <= st_next;
            ir_reg <= ir_next;
            keys_reg <= keys_next;
            cnt_reg <= cnt_next;
            mv_reg <= mv_next;
        end
        item_reg <= item_next;
        tmp_reg <= tmp_next;
        wait_reg <= wait_next;
        row_reg <= row_next;
        out_reg <= out_next;
        ox_reg <= ox_next;
        oy_reg <= oy_next;
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = mv_reg;
    assign m_data = out_reg;

    always_comb begin
        state_next = state_reg;
        item_next = item_reg;
        for (int k = 0; k < 16; k++) v_next[k] = v_reg[k];
        i_next = i_reg;
        pc_next = pc_reg;
        sp_next = sp_reg;
        stk_we = 1'b0;
        stk_wdata = pc2;
        dt_next = dt_reg;
        st_next = st_reg;
        ir_next = ir_reg;
        keys_next = keys_reg;
        cnt_next = cnt_reg;
        tmp_next = tmp_reg;
        wait_next = wait_reg;
        row_next = row_reg;
        mv_next = mv_reg && !m_ready;
        out_next = out_reg;
        ox_next = ox_reg;
        oy_next = oy_reg;
        mem_we = 1'b0;
        mem_waddr = cnt_reg;
        mem_wdata = '0;
        mem_raddr = pc_reg;
        fb_we = 1'b0;
        fb_waddr = cnt_reg[4:0];
        fb_wdata = '0;
        fb_raddr = item_reg.row_select;
        sum9 = '0;
        vf_mid = '0;
        case (state_reg)
            ST_INIT: begin
                mem_we = 1'b1;
                mem_waddr = cnt_reg;
                mem_wdata = ((cnt_reg - 12'(FONT_BASE)) < 12'd80)
                    ? font_byte(7'(cnt_reg - 12'(FONT_BASE))) : 8'h00;
                fb_we = 1'b1;
                fb_waddr = cnt_reg[4:0];
                cnt_next = cnt_reg + 12'd1;
                if (cnt_reg == 12'hFFF) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    item_next = s_data;
                    wait_next = 1'b0;
                    row_next = '0;
                    case (s_data.command)
                        CMD_STEP: state_next = ST_FETCH0;
                        CMD_LOAD: begin
                            mem_we = 1'b1;
                            mem_waddr = s_data.load_address;
                            mem_wdata = s_data.load_byte;
                            state_next = ST_DONE;
                        end
                        CMD_KEY: begin
                            keys_next[s_data.key_index] = s_data.key_down;
                            state_next = ST_DONE;
                        end
                        default: state_next = ST_ROW0;
                    endcase
                end
            end
            ST_ROW0: begin
                state_next = ST_ROW1;
            end
            ST_ROW1: begin
                row_next = fb_rdata;
                state_next = ST_DONE;
            end
            ST_FETCH0: begin
                mem_raddr = pc_reg;
                state_next = ST_FETCH1;
            end
            ST_FETCH1: begin
                mem_raddr = pc_reg + 12'd1;
                tmp_next = mem_rdata;
                state_next = ST_FETCH2;
            end
            ST_FETCH2: begin
                ir_next = {tmp_reg, mem_rdata};
                pc_next = pc2;
                state_next = ST_EXEC;
            end
            ST_EXEC: begin
                state_next = ST_DEC;
                case (ir_reg[15:12])
                    4'h0: begin
                        if (ir_reg == OP_CLS) begin
                            cnt_next = '0;
                            state_next = ST_CLS;
                        end else if (ir_reg == OP_RET) begin
                            pc_next = stk_reg[sp_reg];
                            sp_next = (sp_reg == '0) ? SPW'(STACK_DEPTH - 1)
                                                     : sp_reg - SPW'(1);
                        end
                    end
                    4'h1: pc_next = nnn;
                    4'h2: begin
                        sp_next = (sp_reg == SPW'(STACK_DEPTH - 1)) ? '0
                                                                    : sp_reg + SPW'(1);
                        stk_we = 1'b1;
                        stk_wdata = pc_reg;
                        pc_next = nnn;
                    end
                    4'h3: if (vx == nn) pc_next = pc2;
                    4'h4: if (vx != nn) pc_next = pc2;
                    4'h5: if (vx == vy) pc_next = pc2;
                    4'h6: v_next[x] = nn;
                    4'h7: v_next[x] = vx + nn;
                    4'h8: begin
                        case (n)
                            4'h0: v_next[x] = vy;
                            4'h1: v_next[x] = vx | vy;
                            4'h2: v_next[x] = vx & vy;
                            4'h3: v_next[x] = vx ^ vy;
                            4'h4: begin
                                sum9 = {1'b0, vx} + {1'b0, vy};
                                vf_mid = {7'd0, sum9[8]};
                            end
                            4'h5: vf_mid = {7'd0, vx >= vy};
                            4'h6: vf_mid = {7'd0, vx[0]};
                            4'h7: vf_mid = {7'd0, vy >= vx};
                            4'hE: vf_mid = {7'd0, vx[7]};
                            default: ;
                        endcase
                        if (n inside {4'h4, 4'h5, 4'h6, 4'h7, 4'hE}) begin
                            v_next[15] = vf_mid;
                            tmp_next = vf_mid;
                            state_next = ST_LOADR1;
                            cnt_next = {8'd0, n};
                        end
                    end
                    4'h9: if (vx != vy) pc_next = pc2;
                    4'hA: i_next = nnn;
                    4'hB: pc_next = {4'd0, v_reg[0]} + nnn;
                    4'hC: v_next[x] = item_reg.random_byte & nn;
                    4'hD: begin
                        // The origin is taken before VF is cleared or set by the draw.
                        ox_next = vx[5:0];
                        oy_next = vy[4:0];
                        v_next[15] = '0;
                        cnt_next = '0;
                        state_next = (n == 4'd0) ? ST_DEC : ST_DRAW_RD;
                    end
                    4'hE: begin
                        if (nn == KEY_DOWN_SK && keys_reg[vx[3:0]]) pc_next = pc2;
                        else if (nn == KEY_UP_SK && !keys_reg[vx[3:0]]) pc_next = pc2;
                    end
                    default: begin
                        case (nn)
                            MISC_DLY_RD: v_next[x] = dt_reg;
                            MISC_KEYW: begin
                                if (any_key) v_next[x] = {4'd0, first_key};
                                else begin
                                    pc_next = pc_reg - 12'd2;
                                    wait_next = 1'b1;
                                end
                            end
                            MISC_DLY_WR: dt_next = vx;
                            MISC_SND_WR: st_next = vx;
                            MISC_ADDI: i_next = i_reg + {4'd0, vx};
                            MISC_FONT: i_next = font_off;
                            MISC_BCD: begin
                                mem_we = 1'b1;
                                mem_waddr = i_reg;
                                mem_wdata = hund;
                                tmp_next = ones;
                                cnt_next = {4'd0, tens};
                                state_next = ST_BCD1;
                            end
                            MISC_STORE: begin
                                cnt_next = '0;
                                state_next = ST_STORE;
                            end
                            MISC_LOADR: begin
                                cnt_next = '0;
                                mem_raddr = i_reg;
                                state_next = ST_LOADR0;
                            end
                            default: ;
                        endcase
                    end
                endcase
            end
            ST_LOADR1: begin
                // Second half of 8XY_: the result uses the flag-updated registers.
                case (cnt_reg[3:0])
                    4'h4: v_next[x] = vx + vy;
                    4'h5: v_next[x] = vx - vy;
                    4'h6: v_next[x] = {1'b0, vx[7:1]};
                    4'h7: v_next[x] = vy - vx;
                    default: v_next[x] = {vx[6:0], 1'b0};
                endcase
                state_next = ST_DEC;
            end
            ST_BCD1: begin
                mem_we = 1'b1;
                mem_waddr = i_reg + 12'd1;
                mem_wdata = cnt_reg[7:0];
                state_next = ST_BCD2;
            end
            ST_BCD2: begin
                mem_we = 1'b1;
                mem_waddr = i_reg + 12'd2;
                mem_wdata = tmp_reg;
                state_next = ST_DEC;
            end
            ST_STORE: begin
                mem_we = 1'b1;
                mem_waddr = i_reg + cnt_reg;
                mem_wdata = v_reg[cnt_reg[3:0]];
                cnt_next = cnt_reg + 12'd1;
                if (cnt_reg[3:0] == x) state_next = ST_DEC;
            end
            ST_LOADR0: begin
                mem_raddr = i_reg + cnt_reg + 12'd1;
                v_next[cnt_reg[3:0]] = mem_rdata;
                cnt_next = cnt_reg + 12'd1;
                if (cnt_reg[3:0] == x) state_next = ST_DEC;
            end
            ST_CLS: begin
                fb_we = 1'b1;
                fb_waddr = cnt_reg[4:0];
                cnt_next = cnt_reg + 12'd1;
                if (cnt_reg[4:0] == 5'd31) state_next = ST_DEC;
            end
            ST_DRAW_RD: begin
                if (rowsum[5] || cnt_reg[3:0] == n) state_next = ST_DEC;
                else begin
                    mem_raddr = i_reg + cnt_reg;
                    state_next = ST_DRAW_WT;
                end
            end
            ST_DRAW_WT: begin
                tmp_next = mem_rdata;
                fb_raddr = rowsum[4:0];
                state_next = ST_DRAW_WR;
            end
            ST_DRAW_WR: begin
                fb_we = 1'b1;
                fb_waddr = rowsum[4:0];
                fb_wdata = fb_rdata ^ spr_mask;
                if ((fb_rdata & spr_mask) != '0) v_next[15] = 8'd1;
                cnt_next = cnt_reg + 12'd1;
                state_next = ST_DRAW_RD;
            end
            ST_DEC: begin
                if (dt_reg != '0) dt_next = dt_reg - 8'd1;
                if (st_reg != '0) st_next = st_reg - 8'd1;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!mv_reg || m_ready) begin
                    mv_next = 1'b1;
                    out_next.program_counter = pc_reg;
                    out_next.instruction = ir_reg;
                    out_next.sound_active = (st_reg != '0);
                    out_next.waiting_key = wait_reg;
                    out_next.display_row = row_reg;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    a_no_accept_init: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_INIT |-> !s_ready) else $error("accept during init");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data)) else $error("result lost");
    a_done_move: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DONE && !m_valid |=> m_valid) else $error("result not issued");
endmodule

@@ hw/rtl/c8ic_ram.sv @@
module c8ic_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ bench/tb_chip8_instruction_core_top.sv @@
`timescale 1ns / 1ps

module tb_chip8_instruction_core_top;
    import c8ic_pkg::*;

    localparam int STACK_N   = 16;
    localparam int START_PC  = 512;
    localparam int GLYPH_AT  = 80;
    localparam int N_TARGET  = 1400;
    localparam int PAUSE_AT  = 700;
    localparam int HOLD_AT   = 300;
    localparam int HOLD_LEN  = 500;
    localparam int WD_LIMIT  = 20000;

    localparam bit [7:0] HEX_GLYPHS [80] = '{
        8'hF0,8'h90,8'h90,8'h90,8'hF0, 8'h20,8'h60,8'h20,8'h20,8'h70,
        8'hF0,8'h10,8'hF0,8'h80,8'hF0, 8'hF0,8'h10,8'hF0,8'h10,8'hF0,
        8'h90,8'h90,8'hF0,8'h10,8'h10, 8'hF0,8'h80,8'hF0,8'h10,8'hF0,
        8'hF0,8'h80,8'hF0,8'h90,8'hF0, 8'hF0,8'h10,8'h20,8'h40,8'h40,
        8'hF0,8'h90,8'hF0,8'h90,8'hF0, 8'hF0,8'h90,8'hF0,8'h10,8'hF0,
        8'hF0,8'h90,8'hF0,8'h90,8'h90, 8'hE0,8'h90,8'hE0,8'h90,8'hE0,
        8'hF0,8'h80,8'h80,8'h80,8'hF0, 8'hE0,8'h90,8'h90,8'h90,8'hE0,
        8'hF0,8'h80,8'hF0,8'h80,8'hF0, 8'hF0,8'h80,8'hF0,8'h80,8'h80};

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    c8ic_in_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    c8ic_out_t m_data;

    chip8_instruction_core_top uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always #4 aclk = ~aclk;

    // Machine state as the core should hold it.
    bit [7:0]  vreg [16];
    bit [11:0] ireg, pc;
    int        sp;
    bit [11:0] ret_stack [STACK_N];
    bit [7:0]  dly, snd;
    bit [15:0] ir;
    bit [7:0]  ram [4096];
    bit [63:0] frame [32];
    bit        keys [16];

    c8ic_in_t  pending_items [$];
    c8ic_out_t predicted [$];
    c8ic_out_t awaited [$];
    int n_acc = 0, n_res = 0, err_cnt = 0, idle_cnt = 0;
    int n_steps = 0, n_waits = 0;
    bit gen_done = 1'b0;

    task automatic machine_reset();
        foreach (vreg[i]) vreg[i] = '0;
        ireg = '0;
        pc = 12'(START_PC);
        sp = 0;
        foreach (ret_stack[i]) ret_stack[i] = '0;
        dly = '0;
        snd = '0;
        ir = '0;
        foreach (ram[i]) ram[i] = '0;
        for (int i = 0; i < 80; i++) ram[12'(GLYPH_AT + i)] = HEX_GLYPHS[i];
        foreach (frame[i]) frame[i] = '0;
        foreach (keys[i]) keys[i] = 1'b0;
    endtask

    function automatic void sprite_xor(int x, int y, int n);
        int ox, oy, r, c;
        bit [7:0] bits;
        ox = vreg[x] % 64;
        oy = vreg[y] % 32;
        vreg[15] = 8'd0;
        for (int i = 0; i < n; i++) begin
            bits = ram[12'(ireg + i)];
            r = oy + i;
            if (r >= 32) break;
            for (int j = 0; j < 8; j++) begin
                c = ox + j;
                if (c >= 64) break;
                if (bits[7 - j]) begin
                    if (frame[r][63 - c]) vreg[15] = 8'd1;
                    frame[r][63 - c] = ~frame[r][63 - c];
                end
            end
        end
    endfunction

    function automatic void alu_op(int x, int y, bit [3:0] op);
        case (op)
            4'h0: vreg[x] = vreg[y];
            4'h1: vreg[x] |= vreg[y];
            4'h2: vreg[x] &= vreg[y];
            4'h3: vreg[x] ^= vreg[y];
            4'h4: begin
                vreg[15] = (9'(vreg[x]) + 9'(vreg[y]) > 9'd255) ? 8'd1 : 8'd0;
                vreg[x] = vreg[x] + vreg[y];
            end
            4'h5: begin
                vreg[15] = (vreg[x] >= vreg[y]) ? 8'd1 : 8'd0;
                vreg[x] = vreg[x] - vreg[y];
            end
            4'h6: begin
                vreg[15] = {7'd0, vreg[x][0]};
                vreg[x] = vreg[x] >> 1;
            end
            4'h7: begin
                vreg[15] = (vreg[y] >= vreg[x]) ? 8'd1 : 8'd0;
                vreg[x] = vreg[y] - vreg[x];
            end
            4'hE: begin
                vreg[15] = {7'd0, vreg[x][7]};
                vreg[x] = vreg[x] << 1;
            end
            default: ;
        endcase
    endfunction

    function automatic bit misc_op(int x, bit [7:0] op);
        bit [7:0] v;
        v = vreg[x];
        case (op)
            MISC_DLY_RD: vreg[x] = dly;
            MISC_KEYW: begin
                for (int i = 0; i < 16; i++) begin
                    if (keys[i]) begin
                        vreg[x] = 8'(i);
                        return 1'b0;
                    end
                end
                pc = pc - 12'd2;
                return 1'b1;
            end
            MISC_DLY_WR: dly = v;
            MISC_SND_WR: snd = v;
            MISC_ADDI:   ireg = ireg + 12'(v);
            MISC_FONT:   ireg = 12'(GLYPH_AT + 5 * int'(v));
            MISC_BCD: begin
                ram[ireg] = v / 100;
                ram[12'(ireg + 1)] = (v / 10) % 10;
                ram[12'(ireg + 2)] = v % 10;
            end
            MISC_STORE: for (int i = 0; i <= x; i++) ram[12'(ireg + i)] = vreg[i];
            MISC_LOADR: for (int i = 0; i <= x; i++) vreg[i] = ram[12'(ireg + i)];
            default: ;
        endcase
        return 1'b0;
    endfunction

    function automatic bit execute_step(bit [7:0] rnd);
        bit [15:0] w;
        bit [11:0] nnn;
        bit [7:0]  nn;
        int x, y;
        bit hold;
        w = {ram[pc], ram[12'(pc + 1)]};
        x = w[11:8];
        y = w[7:4];
        nnn = w[11:0];
        nn = w[7:0];
        hold = 1'b0;
        ir = w;
        pc = pc + 12'd2;
        case (w[15:12])
            4'h0: begin
                if (w == OP_CLS) begin
                    foreach (frame[i]) frame[i] = '0;
                end else if (w == OP_RET) begin
                    pc = ret_stack[sp];
                    sp = (sp + STACK_N - 1) % STACK_N;
                end
            end
            4'h1: pc = nnn;
            4'h2: begin
                sp = (sp + 1) % STACK_N;
                ret_stack[sp] = pc;
                pc = nnn;
            end
            4'h3: if (vreg[x] == nn) pc = pc + 12'd2;
            4'h4: if (vreg[x] != nn) pc = pc + 12'd2;
            4'h5: if (vreg[x] == vreg[y]) pc = pc + 12'd2;
            4'h6: vreg[x] = nn;
            4'h7: vreg[x] = vreg[x] + nn;
            4'h8: alu_op(x, y, w[3:0]);
            4'h9: if (vreg[x] != vreg[y]) pc = pc + 12'd2;
            4'hA: ireg = nnn;
            4'hB: pc = 12'(vreg[0]) + nnn;
            4'hC: vreg[x] = rnd & nn;
            4'hD: sprite_xor(x, y, w[3:0]);
            4'hE: begin
                if (nn == KEY_DOWN_SK && keys[vreg[x][3:0]]) pc = pc + 12'd2;
                else if (nn == KEY_UP_SK && !keys[vreg[x][3:0]]) pc = pc + 12'd2;
            end
            default: hold = misc_op(x, nn);
        endcase
        if (dly != 0) dly--;
        if (snd != 0) snd--;
        return hold;
    endfunction

    function automatic c8ic_out_t predict_item(c8ic_in_t it);
        c8ic_out_t r;
        r = '0;
        case (it.command)
            CMD_STEP: r.waiting_key = execute_step(it.random_byte);
            CMD_LOAD: ram[it.load_address] = it.load_byte;
            CMD_KEY:  keys[it.key_index] = it.key_down;
            default:  r.display_row = frame[it.row_select];
        endcase
        r.program_counter = pc;
        r.instruction = ir;
        r.sound_active = (snd != 0);
        return r;
    endfunction

    task automatic queue_item(c8ic_in_t it);
        c8ic_out_t r;
        if (it.command == CMD_STEP) begin
            n_steps++;
        end
        r = predict_item(it);
        if (r.waiting_key) n_waits++;
        pending_items.push_back(it);
        predicted.push_back(r);
    endtask

    function automatic c8ic_in_t noise_item(logic [1:0] cmd);
        c8ic_in_t it;
        it = c8ic_in_t'({$urandom, $urandom});
        it.command = cmd;
        return it;
    endfunction

    // Places an instruction at the current counter and executes it.
    task automatic run_instr(bit [15:0] w);
        c8ic_in_t it;
        it = noise_item(CMD_LOAD);
        it.load_address = pc;
        it.load_byte = w[15:8];
        queue_item(it);
        it = noise_item(CMD_LOAD);
        it.load_address = pc + 12'd1;
        it.load_byte = w[7:0];
        queue_item(it);
        queue_item(noise_item(CMD_STEP));
    endtask

    function automatic bit [15:0] random_instr();
        bit [3:0]  grp;
        bit [11:0] low;
        grp = 4'($urandom_range(0, 15));
        low = 12'($urandom);
        case (grp)
            4'h0: case ($urandom_range(0, 2))
                0: return OP_CLS;
                1: return OP_RET;
                default: return {4'h0, low};
            endcase
            4'h8: case ($urandom_range(0, 9))
                8: return {grp, low[11:4], 4'hE};
                9: return {grp, low};
                default: return {grp, low[11:4], 4'($urandom_range(0, 7))};
            endcase
            4'hE: case ($urandom_range(0, 2))
                0: return {grp, low[11:8], KEY_DOWN_SK};
                1: return {grp, low[11:8], KEY_UP_SK};
                default: return {grp, low};
            endcase
            4'hF: case ($urandom_range(0, 9))
                0: return {grp, low[11:8], MISC_DLY_RD};
                1: return {grp, low[11:8], MISC_KEYW};
                2: return {grp, low[11:8], MISC_DLY_WR};
                3: return {grp, low[11:8], MISC_SND_WR};
                4: return {grp, low[11:8], MISC_ADDI};
                5: return {grp, low[11:8], MISC_FONT};
                6: return {grp, low[11:8], MISC_BCD};
                7: return {grp, low[11:8], MISC_STORE};
                8: return {grp, low[11:8], MISC_LOADR};
                default: return {grp, low};
            endcase
            default: return {grp, low};
        endcase
    endfunction

    task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
        if (err_cnt < 20)
            $display("mismatch at result %0d: %s got %h, expected %h", n_res, field, got, want);
        err_cnt++;
    endtask

    // Acceptance bookkeeping, result checking and the watchdog.
    bit s_took = 1'b0;
    always @(posedge aclk) begin
        c8ic_out_t want;
        s_took <= s_valid && s_ready;
        if (s_valid && s_ready) begin
            awaited.push_back(predicted[n_acc]);
            n_acc <= n_acc + 1;
        end
        if (m_valid && m_ready) begin
            n_res <= n_res + 1;
            if (awaited.size() == 0) begin
                report_mismatch("unexpected item", m_data.program_counter, '0);
            end else begin
                want = awaited.pop_front();
                if (m_data.program_counter != want.program_counter)
                    report_mismatch("program_counter", m_data.program_counter,
                                    want.program_counter);
                if (m_data.instruction != want.instruction)
                    report_mismatch("instruction", m_data.instruction, want.instruction);
                if (m_data.sound_active != want.sound_active)
                    report_mismatch("sound_active", m_data.sound_active, want.sound_active);
                if (m_data.waiting_key != want.waiting_key)
                    report_mismatch("waiting_key", m_data.waiting_key, want.waiting_key);
                if (m_data.display_row != want.display_row)
                    report_mismatch("display_row", m_data.display_row, want.display_row);
            end
        end
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cnt <= 0;
        end else if (idle_cnt + 1 >= WD_LIMIT) begin
            $display("** chip8_instruction_core_top: FAILED **");
            $finish;
        end else begin
            idle_cnt <= idle_cnt + 1;
        end
    end

    function automatic int phase_of(int n);
        if (n < pending_items.size() / 3) return 0;
        if (n < 2 * pending_items.size() / 3) return 1;
        return 2;
    endfunction

    always @(negedge aclk) begin
        int ph;
        ph = phase_of(n_acc);
        if (!aresetn || !gen_done) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_took) begin
            if (n_acc < pending_items.size() &&
                !(n_acc == PAUSE_AT && awaited.size() != 0) &&
                !(ph == 0 && $urandom_range(0, 99) < 19) &&
                !(ph == 1 && $urandom_range(0, 99) < 56)) begin
                s_valid <= 1'b1;
                s_data <= pending_items[n_acc];
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    int hold_left = 0;
    bit held = 1'b0;
    always @(negedge aclk) begin
        int ph;
        ph = phase_of(n_acc);
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (n_res == HOLD_AT && !held) begin
            held = 1'b1;
            hold_left = HOLD_LEN;
            m_ready <= 1'b0;
        end else if (ph == 0) begin
            m_ready <= ($urandom_range(0, 99) >= 56);
        end else if (ph == 1) begin
            m_ready <= ($urandom_range(0, 99) >= 19);
        end else begin
            m_ready <= 1'b1;
        end
    end

    initial begin
        c8ic_in_t it;
        int pick;
        machine_reset();
        run_instr(16'hA050);
        run_instr(16'h60FF);
        run_instr(16'h61FF);
        run_instr(16'hD01F);
        run_instr(16'h8F14);
        run_instr(16'hF00A);
        run_instr(16'h1FFE);
        it = noise_item(CMD_ROW);
        it.row_select = 5'd31;
        queue_item(it);
        it = noise_item(CMD_KEY);
        it.key_index = 4'hF;
        it.key_down = 1'b1;
        queue_item(it);
        while (pending_items.size() < N_TARGET) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) run_instr(random_instr());
            else if (pick < 78) queue_item(noise_item(CMD_KEY));
            else if (pick < 90) queue_item(noise_item(CMD_ROW));
            else if (pick < 95) queue_item(noise_item(CMD_LOAD));
            else queue_item(noise_item(CMD_STEP));
        end
        gen_done = 1'b1;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        while (n_acc < pending_items.size() || awaited.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (awaited.size() != 0) report_mismatch("missing items", awaited.size(), 0);
        $display("Ran %0d items, %0d of them instruction steps (%0d waiting on a key).",
                 pending_items.size(), n_steps, n_waits);
        $display("Checked %0d results under three handshake mixes with one long output stall.",
                 n_res);
        if (err_cnt == 0) begin
            $display("** chip8_instruction_core_top: PASSED **");
        end else begin
            $display("** chip8_instruction_core_top: FAILED **");
        end
        $finish;
    end

endmodule
